>>> src/sfc_pkg.sv
// Shared types, constants and the CRC32C byte update for the state frame checker.
package sfc_pkg;

  localparam int unsigned CountW     = 34;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned HdrBytes   = 36;
  localparam int unsigned HdrCrcSpan = 32;
  localparam int unsigned EndBytes   = 4;
  localparam int unsigned QDepth     = 3;
  localparam int unsigned QCntW      = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [31:0]       CrcPoly  = 32'h82F6_3B78;
  localparam logic [31:0]       CrcInit  = 32'hFFFF_FFFF;

  localparam logic [31:0] MaxPayloadRst    = 32'd16777216;
  localparam logic [31:0] MagicWordRst     = 32'd0;
  localparam logic [15:0] FormatVersionRst = 16'd1;
  localparam logic [31:0] EndWordRst       = 32'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxPayload    = 3'd0,
    CfgMagicWord     = 3'd1,
    CfgFormatVersion = 3'd2,
    CfgEndWord       = 3'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StPartial  = 3'd1,
    StTooLarge = 3'd2,
    StCorrupt  = 3'd3,
    StIncompat = 3'd4,
    StBadCrc   = 3'd5,
    StTrailing = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [31:0] magic_word;
    logic [15:0] format_version;
    logic [31:0] end_word;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [63:0] epoch;
    logic [63:0] sequence_res;
    logic [31:0] decl_len;
  } result_t;

  // Results caused by one accepted byte: a pass-through first, then a verdict.
  typedef struct packed {
    logic    pass_vld;
    logic    verdict_vld;
    result_t pass_res;
    result_t verdict_res;
  } push_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/state_frame_checker.sv
// Top level of the state frame checker: configuration registers, core and result queue.
// Snapshot file checker. Bytes enter one per cycle on the input channel while in_ready_o is
// high (final_byte_i marks the last byte of a file); each byte's results are registered into
// a three-entry result queue. Payload bytes come out as pass-through results, and the final
// byte adds one verdict result with the header's epoch, sequence and length. The output
// channel drains one result per cycle while out_ready_i is high, so the sustained rate is
// one byte per cycle without stalls; a final byte that is also a payload byte yields two
// results and can stall the input. in_ready_o is high while at most one result waits in the
// queue. Configuration writes are meant for times when no file is in flight.
module state_frame_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      final_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic [7:0]                payload_byte_o,
  output logic [2:0]                status_o,
  output logic [63:0]               epoch_o,
  output logic [63:0]               sequence_res_o,
  output logic [31:0]               decl_len_o
);
  import sfc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  push_t   push;
  result_t head;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMaxPayload:    cfg_d.max_payload    = cfg_data_i;
        CfgMagicWord:     cfg_d.magic_word     = cfg_data_i;
        CfgFormatVersion: cfg_d.format_version = cfg_data_i[15:0];
        CfgEndWord:       cfg_d.end_word       = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload    <= MaxPayloadRst;
      cfg_q.magic_word     <= MagicWordRst;
      cfg_q.format_version <= FormatVersionRst;
      cfg_q.end_word       <= EndWordRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .cfg_i        (cfg_q),
    .push_o       (push)
  );

  sfc_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o         = head.kind;
  assign payload_byte_o = head.payload_byte;
  assign status_o       = head.status;
  assign epoch_o        = head.epoch;
  assign sequence_res_o = head.sequence_res;
  assign decl_len_o     = head.decl_len;

  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> (status_o == StOk && decl_len_o == 32'd0))
    else $error("pass-through carries verdict fields");

  a_verdict_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> (payload_byte_o == 8'd0))
    else $error("verdict carries a payload byte");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 3'd7))
    else $error("undefined status code");

endmodule

>>> src/sfc_core.sv
// Header capture, CRCs, payload pass-through and verdict for one accepted byte a cycle.
module sfc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             final_byte_i,
  input  sfc_pkg::cfg_t    cfg_i,
  output sfc_pkg::push_t   push_o
);
  import sfc_pkg::*;

  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [31:0] hdr_crc_q, hdr_crc_d, hdr_crc_u;
  logic [31:0] pay_crc_q, pay_crc_d, pay_crc_u;
  logic [31:0] magic_q, magic_d, magic_u;
  logic [15:0] format_q, format_d, format_u;
  logic [15:0] flags_q, flags_d, flags_u;
  logic [63:0] epoch_q, epoch_d, epoch_u;
  logic [63:0] seq_q, seq_d, seq_u;
  logic [31:0] len_q, len_d, len_u;
  logic [31:0] pcrc_q, pcrc_d, pcrc_u;
  logic [31:0] hcrc_q, hcrc_d, hcrc_u;
  logic [31:0] end_q, end_d, end_u;

  logic [CountW-1:0] off, pay_end, total, expected, size_limit;
  logic              not_sat, pass, in_end;
  logic [1:0]        end_lane;
  status_e           status;

  assign off      = byte_count_q;
  assign pay_end  = CountW'(HdrBytes) + {2'b00, len_q};
  assign not_sat  = (off != CountMax);
  assign end_lane = off[1:0] - len_q[1:0];

  always_comb begin
    hdr_crc_u = hdr_crc_q;
    pay_crc_u = pay_crc_q;
    magic_u   = magic_q;
    format_u  = format_q;
    flags_u   = flags_q;
    epoch_u   = epoch_q;
    seq_u     = seq_q;
    len_u     = len_q;
    pcrc_u    = pcrc_q;
    hcrc_u    = hcrc_q;
    end_u     = end_q;
    pass      = 1'b0;
    in_end    = 1'b0;

    if (off < CountW'(HdrCrcSpan)) begin
      hdr_crc_u = crc32c_byte(hdr_crc_q, data_byte_i);
    end

    // Header fields are zero until their bytes arrive, so a lane write equals an OR.
    if (off < CountW'(4)) begin
      magic_u[8*off[1:0] +: 8] = data_byte_i;
    end else if (off < CountW'(6)) begin
      format_u[8*off[0] +: 8] = data_byte_i;
    end else if (off < CountW'(8)) begin
      flags_u[8*off[0] +: 8] = data_byte_i;
    end else if (off < CountW'(16)) begin
      epoch_u[8*off[2:0] +: 8] = data_byte_i;
    end else if (off < CountW'(24)) begin
      seq_u[8*off[2:0] +: 8] = data_byte_i;
    end else if (off < CountW'(28)) begin
      len_u[8*off[1:0] +: 8] = data_byte_i;
    end else if (off < CountW'(32)) begin
      pcrc_u[8*off[1:0] +: 8] = data_byte_i;
    end else if (off < CountW'(HdrBytes)) begin
      hcrc_u[8*off[1:0] +: 8] = data_byte_i;
    end else if (not_sat && (off < pay_end)) begin
      pass      = 1'b1;
      pay_crc_u = crc32c_byte(pay_crc_q, data_byte_i);
    end else if (not_sat && (off < pay_end + CountW'(EndBytes))) begin
      in_end = 1'b1;
      end_u[8*end_lane +: 8] = data_byte_i;
    end
  end

  assign total      = not_sat ? off + CountW'(1) : off;
  assign expected   = CountW'(HdrBytes + EndBytes) + {2'b00, len_u};
  assign size_limit = {2'b00, cfg_i.max_payload} + CountW'(HdrBytes + 8);

  // Checks in a fixed order; the first failing one decides.
  always_comb begin
    if (total < CountW'(HdrBytes + EndBytes)) begin
      status = StPartial;
    end else if (total > size_limit) begin
      status = StTooLarge;
    end else if (magic_u != cfg_i.magic_word) begin
      status = StCorrupt;
    end else if (format_u != cfg_i.format_version) begin
      status = StIncompat;
    end else if (flags_u != 16'd0) begin
      status = StCorrupt;
    end else if (~hdr_crc_u != hcrc_u) begin
      status = StBadCrc;
    end else if (len_u > cfg_i.max_payload) begin
      status = StTooLarge;
    end else if (total != expected) begin
      status = (total < expected) ? StPartial : StTrailing;
    end else if (~pay_crc_u != pcrc_u) begin
      status = StBadCrc;
    end else if (end_u != cfg_i.end_word) begin
      status = StCorrupt;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    push_o.pass_vld                 = accept_i && pass;
    push_o.pass_res.kind            = 1'b0;
    push_o.pass_res.payload_byte    = data_byte_i;
    push_o.pass_res.status          = StOk;
    push_o.pass_res.epoch           = 64'd0;
    push_o.pass_res.sequence_res    = 64'd0;
    push_o.pass_res.decl_len        = 32'd0;
    push_o.verdict_vld              = accept_i && final_byte_i;
    push_o.verdict_res.kind         = 1'b1;
    push_o.verdict_res.payload_byte = 8'd0;
    push_o.verdict_res.status       = status;
    push_o.verdict_res.epoch        = epoch_u;
    push_o.verdict_res.sequence_res = seq_u;
    push_o.verdict_res.decl_len     = len_u;
  end

  always_comb begin
    byte_count_d = byte_count_q;
    hdr_crc_d    = hdr_crc_q;
    pay_crc_d    = pay_crc_q;
    magic_d      = magic_q;
    format_d     = format_q;
    flags_d      = flags_q;
    epoch_d      = epoch_q;
    seq_d        = seq_q;
    len_d        = len_q;
    pcrc_d       = pcrc_q;
    hcrc_d       = hcrc_q;
    end_d        = end_q;
    if (accept_i) begin
      if (final_byte_i) begin
        byte_count_d = '0;
        hdr_crc_d    = CrcInit;
        pay_crc_d    = CrcInit;
        magic_d      = '0;
        format_d     = '0;
        flags_d      = '0;
        epoch_d      = '0;
        seq_d        = '0;
        len_d        = '0;
        pcrc_d       = '0;
        hcrc_d       = '0;
        end_d        = '0;
      end else begin
        byte_count_d = total;
        hdr_crc_d    = hdr_crc_u;
        pay_crc_d    = pay_crc_u;
        magic_d      = magic_u;
        format_d     = format_u;
        flags_d      = flags_u;
        epoch_d      = epoch_u;
        seq_d        = seq_u;
        len_d        = len_u;
        pcrc_d       = pcrc_u;
        hcrc_d       = hcrc_u;
        end_d        = end_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      hdr_crc_q    <= CrcInit;
      pay_crc_q    <= CrcInit;
      magic_q      <= '0;
      format_q     <= '0;
      flags_q      <= '0;
      epoch_q      <= '0;
      seq_q        <= '0;
      len_q        <= '0;
      pcrc_q       <= '0;
      hcrc_q       <= '0;
      end_q        <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      hdr_crc_q    <= hdr_crc_d;
      pay_crc_q    <= pay_crc_d;
      magic_q      <= magic_d;
      format_q     <= format_d;
      flags_q      <= flags_d;
      epoch_q      <= epoch_d;
      seq_q        <= seq_d;
      len_q        <= len_d;
      pcrc_q       <= pcrc_d;
      hcrc_q       <= hcrc_d;
      end_q        <= end_d;
    end
  end

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && final_byte_i) |=> (byte_count_q == '0))
    else $error("byte count not cleared after a verdict");

  a_pass_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.pass_vld |-> (byte_count_q >= CountW'(HdrBytes)))
    else $error("pass-through inside the header");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !final_byte_i) |=> (byte_count_q >= $past(byte_count_q)))
    else $error("byte count went backward within a file");

  a_end_not_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pass && in_end))
    else $error("byte taken as both payload and end word");

endmodule

>>> src/sfc_res_queue.sv
// Three-entry result queue between the checker core and the output channel.
module sfc_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfc_pkg::push_t     push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfc_pkg::result_t   head_o
);
  import sfc_pkg::*;

  result_t           ent_q [QDepth];
  result_t           ent_d [QDepth];
  logic [QCntW-1:0]  count_q, count_d, base, verdict_pos;
  logic              pop;

  assign out_valid_o = (count_q != '0);
  assign head_o      = ent_q[0];
  // Room for the two results one byte may cause.
  assign room_o      = (count_q <= QCntW'(1));
  assign pop         = out_valid_o && out_ready_i;
  assign base        = count_q - QCntW'(pop);
  assign verdict_pos = base + QCntW'(push_i.pass_vld);
  assign count_d     = verdict_pos + QCntW'(push_i.verdict_vld);

  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      ent_d[i] = pop ? ent_q[i+1] : ent_q[i];
    end
    ent_d[QDepth-1] = ent_q[QDepth-1];
    for (int i = 0; i < QDepth; i++) begin
      if (push_i.pass_vld && (base == QCntW'(i))) begin
        ent_d[i] = push_i.pass_res;
      end
      if (push_i.verdict_vld && (verdict_pos == QCntW'(i))) begin
        ent_d[i] = push_i.verdict_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.pass_vld || push_i.verdict_vld) |-> room_o)
    else $error("result pushed without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.pass_vld && !push_i.verdict_vld) |=>
      (count_q == $past(count_q) - QCntW'(1)))
    else $error("queue count wrong after a transfer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

endmodule

>>> bench/sfc_stream_monitor.sv
`timescale 1ns / 100ps
// CRC32C helper package and the monitor that predicts and checks every result of the frame checker.
package frame_crc_pkg;

  // Bit-serial CRC32C step: each data bit is folded into the feedback on its own.
  function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? sfc_pkg::CrcPoly : 32'h0);
    end
    return c;
  endfunction

endpackage

module sfc_stream_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         final_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         kind_i,
  input  logic [7:0]                   payload_byte_i,
  input  logic [2:0]                   status_i,
  input  logic [63:0]                  epoch_i,
  input  logic [63:0]                  sequence_res_i,
  input  logic [31:0]                  decl_len_i,
  output int                           mismatch_count_o,
  output int                           awaited_o
);
  import sfc_pkg::*;
  import frame_crc_pkg::*;

  // Header field offsets within the file.
  localparam int unsigned OffFormat = 4;
  localparam int unsigned OffFlags  = 6;
  localparam int unsigned OffEpoch  = 8;
  localparam int unsigned OffSeq    = 16;
  localparam int unsigned OffLen    = 24;
  localparam int unsigned OffPayCrc = 28;
  // The size check allows eight bytes beyond the header and the largest payload.
  localparam int unsigned SizeSlack = 8;

  localparam logic KindPass    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  result_t awaited_results[$];
  cfg_t    live_cfg;
  int      mismatches;
  int      results_seen;

  logic [CountW-1:0] byte_pos;
  logic [31:0]       hdr_crc;
  logic [31:0]       pay_crc;
  logic [31:0]       got_magic;
  logic [15:0]       got_format;
  logic [15:0]       got_flags;
  logic [63:0]       got_epoch;
  logic [63:0]       got_seq;
  logic [31:0]       got_len;
  logic [31:0]       got_pay_crc;
  logic [31:0]       got_hdr_crc;
  logic [31:0]       got_end;

  function automatic void clear_stream();
    byte_pos    = '0;
    hdr_crc     = CrcInit;
    pay_crc     = CrcInit;
    got_magic   = '0;
    got_format  = '0;
    got_flags   = '0;
    got_epoch   = '0;
    got_seq     = '0;
    got_len     = '0;
    got_pay_crc = '0;
    got_hdr_crc = '0;
    got_end     = '0;
  endfunction

  function automatic status_e judge_file(input logic [63:0] total);
    logic [63:0] want_total;
    want_total = 64'(HdrBytes) + 64'(got_len) + 64'(EndBytes);
    if (total < 64'(HdrBytes + EndBytes)) return StPartial;
    if (total > 64'(live_cfg.max_payload) + 64'(HdrBytes) + 64'(SizeSlack)) return StTooLarge;
    if (got_magic != live_cfg.magic_word) return StCorrupt;
    if (got_format != live_cfg.format_version) return StIncompat;
    if (got_flags != '0) return StCorrupt;
    if (~hdr_crc != got_hdr_crc) return StBadCrc;
    if (got_len > live_cfg.max_payload) return StTooLarge;
    if (total != want_total) return (total < want_total) ? StPartial : StTrailing;
    if (~pay_crc != got_pay_crc) return StBadCrc;
    if (got_end != live_cfg.end_word) return StCorrupt;
    return StOk;
  endfunction

  // Folds one accepted byte into the stream state and queues the results it causes.
  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    logic [63:0] off;
    logic [63:0] pay_end;
    result_t     r;
    off     = 64'(byte_pos);
    pay_end = 64'(HdrBytes) + 64'(got_len);
    if (off < 64'(HdrCrcSpan)) hdr_crc = crc32c_step(hdr_crc, b);

    if (off < OffFormat) begin
      got_magic |= 32'(b) << (8 * off);
    end else if (off < OffFlags) begin
      got_format |= 16'(b) << (8 * (off - OffFormat));
    end else if (off < OffEpoch) begin
      got_flags |= 16'(b) << (8 * (off - OffFlags));
    end else if (off < OffSeq) begin
      got_epoch |= 64'(b) << (8 * (off - OffEpoch));
    end else if (off < OffLen) begin
      got_seq |= 64'(b) << (8 * (off - OffSeq));
    end else if (off < OffPayCrc) begin
      got_len |= 32'(b) << (8 * (off - OffLen));
    end else if (off < HdrCrcSpan) begin
      got_pay_crc |= 32'(b) << (8 * (off - OffPayCrc));
    end else if (off < HdrBytes) begin
      got_hdr_crc |= 32'(b) << (8 * (off - HdrCrcSpan));
    end else if (off < 64'(CountMax) && off < pay_end) begin
      pay_crc        = crc32c_step(pay_crc, b);
      r              = '0;
      r.kind         = KindPass;
      r.payload_byte = b;
      r.status       = StOk;
      awaited_results.push_back(r);
    end else if (off < 64'(CountMax) && off < pay_end + 64'(EndBytes)) begin
      got_end |= 32'(b) << (8 * (off - pay_end));
    end

    // The count sticks at its top value on very long files.
    if (byte_pos != CountMax) byte_pos++;

    if (is_last) begin
      r              = '0;
      r.kind         = KindVerdict;
      r.status       = judge_file(64'(byte_pos));
      r.epoch        = got_epoch;
      r.sequence_res = got_seq;
      r.decl_len     = got_len;
      awaited_results.push_back(r);
      clear_stream();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] seen);
    mismatches++;
    $display("%0t: result %0d, %s: expected %0h, got %0h",
             $time, results_seen, what, want, seen);
  endtask

  task automatic compare_result();
    result_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      note_mismatch("result with nothing awaited", '0,
                    64'({kind_i, status_i, payload_byte_i}));
    end else begin
      want = awaited_results.pop_front();
      if (kind_i !== want.kind) note_mismatch("kind", 64'(want.kind), 64'(kind_i));
      if (payload_byte_i !== want.payload_byte) begin
        note_mismatch("payload_byte", 64'(want.payload_byte), 64'(payload_byte_i));
      end
      if (status_i !== want.status) begin
        note_mismatch("status", 64'(want.status), 64'(status_i));
      end
      if (epoch_i !== want.epoch) note_mismatch("epoch", want.epoch, epoch_i);
      if (sequence_res_i !== want.sequence_res) begin
        note_mismatch("sequence_res", want.sequence_res, sequence_res_i);
      end
      if (decl_len_i !== want.decl_len) begin
        note_mismatch("decl_len", 64'(want.decl_len), 64'(decl_len_i));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      live_cfg.max_payload    = MaxPayloadRst;
      live_cfg.magic_word     = MagicWordRst;
      live_cfg.format_version = FormatVersionRst;
      live_cfg.end_word       = EndWordRst;
      clear_stream();
      awaited_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      // A result leaves no earlier than the cycle after its byte, so check before predicting.
      if (out_valid_i && out_ready_i) compare_result();
      if (in_valid_i && in_ready_i) absorb_byte(data_byte_i, final_byte_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgMaxPayload:    live_cfg.max_payload = cfg_data_i;
          CfgMagicWord:     live_cfg.magic_word = cfg_data_i;
          CfgFormatVersion: live_cfg.format_version = cfg_data_i[15:0];
          CfgEndWord:       live_cfg.end_word = cfg_data_i;
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    awaited_o        <= awaited_results.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the state frame checker: clock, reset, snapshot file stimulus and verdict.
module tb_top;
  import sfc_pkg::*;
  import frame_crc_pkg::*;

  typedef enum int unsigned {
    FileGood,
    FileBadMagic,
    FileBadFormat,
    FileFlagsSet,
    FileBadHdrCrc,
    FileLongLen,
    FileShort,
    FileCutPayload,
    FileTrailing,
    FileBadPayCrc,
    FileBadEnd,
    FileOversize,
    FileNoise
  } file_flaw_e;

  localparam int unsigned NumRegs     = int'(CfgEndWord) + 1;
  localparam int unsigned LastIdx     = (1 << CfgIdxW) - 1;
  localparam int unsigned IdleCycles  = 8;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned PhaseFiles  = 8;
  localparam int unsigned TargetBytes = 1200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                final_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                kind_o;
  logic [7:0]          payload_byte_o;
  logic [2:0]          status_o;
  logic [63:0]         epoch_o;
  logic [63:0]         sequence_res_o;
  logic [31:0]         decl_len_o;
  int                  mismatches;
  int                  awaited;

  logic [31:0] cur_max    = MaxPayloadRst;
  logic [31:0] cur_magic  = MagicWordRst;
  logic [15:0] cur_format = FormatVersionRst;
  logic [31:0] cur_end    = EndWordRst;
  logic [7:0]  file_bytes[$];
  bit          feed_calm;
  int          bytes_sent;

  state_frame_checker dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .data_byte_i, .final_byte_i,
    .out_valid_o, .out_ready_i, .kind_o, .payload_byte_o, .status_o,
    .epoch_o, .sequence_res_o, .decl_len_o
  );

  sfc_stream_monitor u_monitor (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i (in_ready_o), .data_byte_i, .final_byte_i,
    .out_valid_i (out_valid_o), .out_ready_i, .kind_i (kind_o),
    .payload_byte_i (payload_byte_o), .status_i (status_o), .epoch_i (epoch_o),
    .sequence_res_i (sequence_res_o), .decl_len_i (decl_len_o),
    .mismatch_count_o (mismatches), .awaited_o (awaited)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Builds file_bytes: a consistent frame with the chosen defect, or noise for FileNoise.
  task automatic build_file(input file_flaw_e flaw, input bit extreme);
    file_flaw_e  f;
    logic [31:0] len;
    logic [31:0] pcrc;
    logic [31:0] hcrc;
    logic [63:0] ep;
    logic [63:0] sq;
    logic [7:0]  body[$];
    int          n;
    int          cut;
    int          full;
    f   = flaw;
    cut = 0;
    file_bytes.delete();
    if (f == FileNoise) begin
      n = $urandom_range(1, 60);
      repeat (n) file_bytes.push_back(8'($urandom()));
      return;
    end
    if (f == FileLongLen && cur_max == '1) f = FileGood;
    if (f == FileOversize && cur_max > 200) f = FileTrailing;

    if (f == FileLongLen) begin
      len = cur_max + 1 + ($urandom() % (32'hFFFF_FFFF - cur_max));
      n   = 4;
    end else begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      if (len > cur_max) len = cur_max;
      n = int'(len);
    end
    pcrc = CrcInit;
    repeat (n) begin
      body.push_back(8'($urandom()));
      pcrc = crc32c_step(pcrc, body[body.size()-1]);
    end
    pcrc = ~pcrc;
    if (f == FileBadPayCrc) pcrc ^= 32'h1 << $urandom_range(0, 31);
    ep = extreme ? '1 : {$urandom(), $urandom()};
    sq = extreme ? '0 : {$urandom(), $urandom()};

    put_le(64'(cur_magic ^ ((f == FileBadMagic) ? 32'h1 << $urandom_range(0, 31) : 32'h0)), 4);
    put_le(64'(cur_format ^ ((f == FileBadFormat) ? 16'h1 << $urandom_range(0, 15) : 16'h0)),
           2);
    put_le(64'((f == FileFlagsSet) ? $urandom_range(1, 16'hFFFF) : 0), 2);
    put_le(ep, 8);
    put_le(sq, 8);
    put_le(64'(len), 4);
    put_le(64'(pcrc), 4);
    hcrc = CrcInit;
    for (int i = 0; i < HdrCrcSpan; i++) hcrc = crc32c_step(hcrc, file_bytes[i]);
    hcrc = ~hcrc;
    if (f == FileBadHdrCrc) hcrc ^= 32'h1 << $urandom_range(0, 31);
    put_le(64'(hcrc), 4);
    foreach (body[i]) file_bytes.push_back(body[i]);
    put_le(64'(cur_end ^ ((f == FileBadEnd) ? 32'h1 << $urandom_range(0, 31) : 32'h0)), 4);

    case (f)
      FileShort:      cut = $urandom_range(1, HdrBytes + EndBytes - 1);
      FileCutPayload: cut = $urandom_range(HdrBytes + 1, file_bytes.size() - 1);
      FileTrailing: begin
        repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom()));
      end
      FileOversize: begin
        // Anything past max_payload plus header and two words is refused by size alone.
        full = int'(cur_max) + HdrBytes + 2 * EndBytes + 1 + $urandom_range(0, 3);
        while (file_bytes.size() < full) file_bytes.push_back(8'($urandom()));
      end
      default: ;
    endcase
    if (cut > 0) begin
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if ($urandom_range(0, 63) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i   <= 1'b0;
      data_byte_i  <= 8'($urandom());
      final_byte_i <= 1'($urandom());
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Stops feeding and waits until every predicted result is out or DrainLimit runs out.
  task automatic settle();
    int spins;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    spins = 0;
    while (awaited != 0 && spins < DrainLimit) begin
      @(negedge clk_i);
      spins++;
    end
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CfgMaxPayload:    cur_max = val;
      CfgMagicWord:     cur_magic = val;
      CfgFormatVersion: cur_format = val[15:0];
      CfgEndWord:       cur_end = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  task automatic configure(input int phase);
    logic [31:0] mx;
    logic [31:0] mg;
    logic [15:0] fv;
    logic [31:0] ew;
    if (phase == 0) begin
      mx = '0;
      mg = '0;
      fv = '0;
      ew = '0;
    end else if (phase == 1) begin
      mx = '1;
      mg = '1;
      fv = '1;
      ew = '1;
    end else begin
      mx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) : pick_value();
      mg = pick_value();
      fv = 16'(pick_value());
      ew = pick_value();
    end
    write_reg(CfgMaxPayload, mx);
    write_reg(CfgMagicWord, mg);
    // The upper half of the format write carries junk that the block must drop.
    write_reg(CfgFormatVersion, {16'($urandom()), fv});
    write_reg(CfgEndWord, ew);
    // Writes to unused indexes come last so that any aliasing would show.
    if (phase == 0 || $urandom_range(0, 1) == 1) begin
      write_reg(CfgIdxW'($urandom_range(NumRegs, LastIdx)), $urandom());
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : drain
    int stall;
    bit calm;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    file_flaw_e flaw;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    final_byte_i = 1'b0;
    feed_calm    = 1'b0;
    bytes_sent   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // One file of each kind under the reset settings, where oversize turns into trailing.
    for (int k = 0; k <= int'(FileNoise); k++) begin
      build_file(file_flaw_e'(k), k == int'(FileGood));
      send_file();
    end

    for (int phase = 0; bytes_sent < TargetBytes; phase++) begin
      settle();
      configure(phase);
      for (int j = 0; j < PhaseFiles && bytes_sent < TargetBytes; j++) begin
        if ($urandom_range(0, 1) == 0) flaw = FileGood;
        else flaw = file_flaw_e'($urandom_range(int'(FileBadMagic), int'(FileNoise)));
        build_file(flaw, 1'b0);
        send_file();
      end
    end

    settle();
    if (mismatches == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/sfc_pkg.sv
src/sfc_core.sv
src/sfc_res_queue.sv
src/state_frame_checker.sv
bench/sfc_stream_monitor.sv
bench/tb_top.sv
